// ===== hdl/cluster_vertex_index_remap_assert.svh =====
// ----------------------------------------------------------------------------
// cluster vertex index remap assertion macros
// concurrent checks on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef CLUSTER_VERTEX_INDEX_REMAP_ASSERT_SVH
`define CLUSTER_VERTEX_INDEX_REMAP_ASSERT_SVH

`ifndef SYNTHESIS
// check that a property holds at every clock edge out of reset
`define CVIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// check that an expression is never true
`define CVIR_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define CVIR_ASSERT(lbl, prop, msg)
`define CVIR_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// ===== hdl/cvir_pkg.sv =====
// ----------------------------------------------------------------------------
// cvir_pkg
// shared types and constants of the cluster vertex index remap block
// ----------------------------------------------------------------------------
package cvir_pkg;

  // early table slots, the slot is taken from the low index bits
  localparam int unsigned EARLY_ENTRIES = 256;

  // request payload
  typedef struct packed {
    logic [31:0] vertex_index;
    logic        cluster_start;
  } in_t;

  // result payload
  typedef struct packed {
    logic [7:0] local_index;
    logic       new_vertex;
    logic [8:0] vtx_count;
    logic       overflow;
  } out_t;

  // where a resolved result takes its position from
  typedef enum logic [1:0] {
    RES_EARLY = 2'd0,
    RES_SCAN  = 2'd1,
    RES_MISS  = 2'd2
  } res_src_e;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     scan_start;
    logic     scan_run;
    logic     resolve;
    res_src_e src;
    logic     emit_now;
    logic     emit_held;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic early_hit;
    logic count_zero;
    logic scan_match;
    logic scan_done;
    logic out_free;
  } sts_t;

  // register map, word index taken from paddr[2]
  localparam logic       REG_VTX_LIMIT = 1'b0;
  localparam logic [8:0] VTX_LIMIT_RST = 9'd64;

endpackage

// ===== hdl/cluster_vertex_index_remap.sv =====
// ----------------------------------------------------------------------------
// cluster_vertex_index_remap
// maps global vertex indices of a cluster to compact local vertex indices
// ----------------------------------------------------------------------------
// Requests carry one global vertex index and a cluster_start flag; each one
// gives exactly one result: local index, new-vertex flag, vertex count and
// overflow flag. Both channels use valid/stall.
// One request is in flight at a time. An early-table hit goes through accept,
// then lookup in the registered early table, as does any request into an
// empty cluster. On a miss the local vertex list memory is scanned one entry
// per cycle through its single read port until a match, a new vertex or an
// overflow resolves the request.
// The result goes into an output register, so a stalled receiver does not
// block the next request; a second finished result waits internally and
// holds the input stalled until the output register frees up.
// Reset clears all early-table valid bits and the vertex count, and sets
// the vertex limit to 64; no clearing pass is needed. The APB port holds one
// register, the vertex limit, at byte address 0.
// ----------------------------------------------------------------------------
module cluster_vertex_index_remap
  import cvir_pkg::*;
#(
  parameter int unsigned LOCAL_DEPTH   = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "cluster_vertex_index_remap_assert.svh"

  cmd_t       cmd;
  sts_t       sts;
  logic [8:0] vtx_limit_q;
  logic       reg_hit;
  logic       in_acc;
  logic       ovf_dirty;
  logic       new_at_end;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_VTX_LIMIT);
  assign prdata  = reg_hit ? {23'b0, vtx_limit_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx_limit_q <= VTX_LIMIT_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      vtx_limit_q <= pwdata[8:0];
    end
  end

  cvir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cvir_dpath #(
    .LOCAL_DEPTH   (LOCAL_DEPTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .vtx_limit_i    (vtx_limit_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_o          (out_o)
  );

  assign in_acc     = in_valid_i && !in_stall_o;
  assign ovf_dirty  = out_o.new_vertex || (out_o.local_index != 8'd0);
  assign new_at_end = (9'(out_o.local_index) + 9'd1) == out_o.vtx_count;

  // one request in flight
  `CVIR_ASSERT(a_one_in_flight, in_acc |=> in_stall_o, "request accepted while busy")
  `CVIR_ASSERT_NEVER(a_ovf_clean, out_valid_o && out_o.overflow && ovf_dirty, "overflow with index")
  `CVIR_ASSERT(a_new_is_last, (out_valid_o && out_o.new_vertex) |-> new_at_end, "new vertex not last")
  `CVIR_ASSERT_NEVER(a_count_range, out_valid_o && (out_o.vtx_count > 9'(LOCAL_DEPTH)), "count too big")

endmodule

// ===== hdl/cvir_ctrl.sv =====
// ----------------------------------------------------------------------------
// cvir_ctrl
// sequencer: early lookup, list scan on a miss, result hand-off
// ----------------------------------------------------------------------------
module cvir_ctrl
  import cvir_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOOKUP = 4'b0010,
    S_SEARCH = 4'b0100,
    S_EMIT   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.src  = RES_MISS;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (sts_i.early_hit || sts_i.count_zero) begin
          cmd_o.resolve  = 1'b1;
          cmd_o.src      = sts_i.early_hit ? RES_EARLY : RES_MISS;
          cmd_o.emit_now = sts_i.out_free;
          state_d        = sts_i.out_free ? S_IDLE : S_EMIT;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_match || sts_i.scan_done) begin
          cmd_o.resolve  = 1'b1;
          cmd_o.src      = sts_i.scan_match ? RES_SCAN : RES_MISS;
          cmd_o.emit_now = sts_i.out_free;
          state_d        = sts_i.out_free ? S_IDLE : S_EMIT;
        end
      end
      S_EMIT: begin
        // result parked until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.emit_held = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/cvir_dpath.sv =====
// ----------------------------------------------------------------------------
// cvir_dpath
// early table, local vertex list, scan pointer, result and output registers
// ----------------------------------------------------------------------------
module cvir_dpath
  import cvir_pkg::*;
#(
  parameter int unsigned LOCAL_DEPTH   = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_t        in_i,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  input  logic [8:0] vtx_limit_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_o
);

  localparam int unsigned EA = $clog2(EARLY_ENTRIES);
  localparam int unsigned LA = $clog2(LOCAL_DEPTH);
  localparam int unsigned CW = $clog2(LOCAL_DEPTH + 1);
  localparam logic [8:0]  DEPTH9 = 9'(LOCAL_DEPTH);

  // early table (slot = low index bits, table size is a power of two)
  logic [31:0]   early_tag_mem [EARLY_ENTRIES];
  logic [LA-1:0] early_pos_mem [EARLY_ENTRIES];
  logic [EARLY_ENTRIES-1:0] early_valid_q;
  logic [31:0]   e_tag_rd_q;
  logic [LA-1:0] e_pos_rd_q;
  logic          ev_q;

  // local vertex list
  logic [31:0]   local_mem [LOCAL_DEPTH];
  logic [31:0]   l_rd_q;
  logic          l_vld_q;
  logic [LA-1:0] l_idx_q;
  logic [CW-1:0] scan_addr_q;

  logic [31:0]   vidx_q;
  logic [CW-1:0] count_q;
  out_t          res_q, res_d, out_q;
  logic          out_valid_q;

  logic [EA-1:0] in_slot, slot_q;
  logic          issue, match, hit, ovf_cond, append;
  logic [8:0]    lim9;

  assign in_slot = in_i.vertex_index[EA-1:0];
  assign slot_q  = vidx_q[EA-1:0];

  assign issue = cmd_i.scan_run && (scan_addr_q < count_q);
  assign match = l_vld_q && (l_rd_q == vidx_q);
  assign hit   = ev_q && (e_tag_rd_q == vidx_q);

  assign lim9     = (vtx_limit_i > DEPTH9) ? DEPTH9 : vtx_limit_i;
  assign ovf_cond = 9'(count_q) >= lim9;
  assign append   = cmd_i.resolve && (cmd_i.src == RES_MISS) && !ovf_cond;

  always_comb begin
    res_d           = '0;
    res_d.vtx_count = 9'(count_q);
    case (cmd_i.src)
      RES_EARLY: res_d.local_index = 8'(e_pos_rd_q);
      RES_SCAN:  res_d.local_index = 8'(l_idx_q);
      RES_MISS: begin
        if (ovf_cond) begin
          res_d.overflow = 1'b1;
        end else begin
          res_d.local_index = 8'(count_q[LA-1:0]);
          res_d.new_vertex  = 1'b1;
          res_d.vtx_count   = 9'(count_q + CW'(1));
        end
      end
      default: res_d = '0;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      e_tag_rd_q <= early_tag_mem[in_slot];
      e_pos_rd_q <= early_pos_mem[in_slot];
    end
    if (append) begin
      early_tag_mem[slot_q] <= vidx_q;
      early_pos_mem[slot_q] <= count_q[LA-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      l_rd_q <= local_mem[scan_addr_q[LA-1:0]];
    end
    if (append) begin
      local_mem[count_q[LA-1:0]] <= vidx_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      vidx_q <= in_i.vertex_index;
    end
    if (issue) begin
      l_idx_q <= scan_addr_q[LA-1:0];
    end
    if (cmd_i.resolve) begin
      res_q <= res_d;
    end
    if (cmd_i.emit_now) begin
      out_q <= res_d;
    end else if (cmd_i.emit_held) begin
      out_q <= res_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      early_valid_q <= '0;
      ev_q          <= 1'b0;
      count_q       <= '0;
      scan_addr_q   <= '0;
      l_vld_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        // a cluster start empties the table before the lookup
        if (in_i.cluster_start) begin
          early_valid_q <= '0;
          count_q       <= '0;
          ev_q          <= 1'b0;
        end else begin
          ev_q <= early_valid_q[in_slot];
        end
      end
      if (append) begin
        early_valid_q[slot_q] <= 1'b1;
        count_q               <= count_q + CW'(1);
      end
      if (cmd_i.scan_start) begin
        scan_addr_q <= '0;
        l_vld_q     <= 1'b0;
      end else if (cmd_i.scan_run) begin
        l_vld_q <= issue;
        if (issue) begin
          scan_addr_q <= scan_addr_q + CW'(1);
        end
      end
      if (cmd_i.emit_now || cmd_i.emit_held) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.early_hit  = hit;
  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.scan_match = match;
  // nothing left to read and the entry under compare is not it
  assign sts_o.scan_done  = (scan_addr_q >= count_q) && !match;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: cluster vertex index remap testbench
// Drives global vertex indices grouped into clusters and checks every
// local-index result against an internal remap predictor. Covers direct-slot
// hits, list-search hits, slot collisions, overflow at several vertex limits,
// random source/sink idling, two long sink hold-offs and a full drain pause.
// ----------------------------------------------------------------------------
module tb;
  import cvir_pkg::*;

  localparam int         IDLE_LIMIT     = 4000;
  localparam int         HOLD_CYCLES    = 300;
  localparam logic [2:0] VTX_LIMIT_ADDR = {REG_VTX_LIMIT, 2'b00};

  // predictor plus the queue of local-index results still to come
  class remap_scoreboard;
    out_t        pending_remaps[$];
    logic [31:0] slot_tag [256];
    bit          slot_live [256];
    logic [7:0]  slot_pos [256];
    logic [31:0] seen_list [256];
    logic [8:0]  seen_count;
    logic [8:0]  vtx_cap;
    int          errors, n_requests, n_results, n_new, n_ovf;
    int          n_slot_hits, n_list_hits, n_clusters;

    function new();
      foreach (slot_live[k]) slot_live[k] = 1'b0;
      seen_count = '0;
      vtx_cap    = VTX_LIMIT_RST;
    endfunction

    function out_t remap_vertex(in_t req);
      logic [7:0] slot;
      logic [8:0] cap_eff;
      out_t       res;
      bit         found;
      int         k;
      slot  = req.vertex_index[7:0];
      found = 1'b0;
      res   = '0;
      if (req.cluster_start) begin
        foreach (slot_live[j]) slot_live[j] = 1'b0;
        seen_count = '0;
        n_clusters++;
      end
      if (slot_live[slot] && slot_tag[slot] == req.vertex_index) begin
        res.local_index = slot_pos[slot];
        found = 1'b1;
        n_slot_hits++;
      end else begin
        for (k = 0; k < int'(seen_count); k++) begin
          if (seen_list[k] == req.vertex_index) begin
            res.local_index = k[7:0];
            found = 1'b1;
          end
        end
        if (found) n_list_hits++;
      end
      if (!found) begin
        cap_eff = (vtx_cap > 9'd256) ? 9'd256 : vtx_cap;
        if (seen_count >= cap_eff) begin
          res.overflow = 1'b1;
          n_ovf++;
        end else begin
          res.local_index             = seen_count[7:0];
          seen_list[int'(seen_count)] = req.vertex_index;
          slot_tag[slot]              = req.vertex_index;
          slot_live[slot]             = 1'b1;
          slot_pos[slot]              = seen_count[7:0];
          seen_count                  = seen_count + 9'd1;
          res.new_vertex              = 1'b1;
          n_new++;
        end
      end
      res.vtx_count = seen_count;
      return res;
    endfunction

    function void note_request(in_t req);
      n_requests++;
      pending_remaps.insert(pending_remaps.size(), remap_vertex(req));
    endfunction

    function void check_result(out_t got);
      out_t want;
      n_results++;
      if (pending_remaps.size() == 0) begin
        $error("result with no request pending: %p", got);
        errors++;
        return;
      end
      want = pending_remaps.pop_front();
      if (got.local_index !== want.local_index) begin
        $error("local_index: expected %0d, got %0d", want.local_index, got.local_index);
        errors++;
      end
      if (got.new_vertex !== want.new_vertex) begin
        $error("new_vertex: expected %0d, got %0d", want.new_vertex, got.new_vertex);
        errors++;
      end
      if (got.vtx_count !== want.vtx_count) begin
        $error("vtx_count: expected %0d, got %0d", want.vtx_count, got.vtx_count);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_t         in_i        = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  remap_scoreboard sb = new();
  int  sent_total = 0;
  int  idle_cycles = 0;
  bit  src_burst = 1'b0;
  bit  sink_burst = 1'b0;

  cluster_vertex_index_remap DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // monitor both channels and the watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(in_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result sink with random stalls and two long hold-offs
  initial begin : result_sink
    int wait_n;
    int holds_done;
    holds_done = 0;
    forever begin
      if (holds_done < 2 && sb.n_results >= (holds_done == 0 ? 200 : 700)) begin
        wait_n = HOLD_CYCLES;
        holds_done++;
      end else begin
        wait_n = sink_burst ? 0 : $urandom_range(0, 10);
      end
      if (wait_n > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
    end
  end

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending_remaps.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_vtx(logic [31:0] vtx, logic start);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= '{vertex_index: vtx, cluster_start: start};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_total++;
    if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
    // one full drain in the middle of the run
    if (sent_total == 500) wait_drained();
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(logic [2:0] addr, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_vertex_cap(logic [8:0] cap);
    logic [31:0] rd;
    wait_drained();
    repeat (8) @(posedge clk_i);
    apb_write(VTX_LIMIT_ADDR, {23'd0, cap});
    sb.vtx_cap = cap;
    apb_read(VTX_LIMIT_ADDR, rd);
    if (rd[8:0] !== cap) begin
      $error("vtx_limit: expected %0d, got %0d", cap, rd[8:0]);
      sb.errors++;
    end
  endtask

  // one cluster: new vertices introduced over time, revisits, some noise
  task automatic run_cluster(int distinct, int new_pct);
    logic [31:0] pool[$];
    logic [31:0] vtx;
    logic [7:0]  hot_slot;
    bit          alias_mode;
    int          used, len, i;
    alias_mode = ($urandom_range(0, 2) == 0);
    hot_slot   = 8'($urandom());
    for (i = 0; i < distinct; i++) begin
      vtx = $urandom();
      // crowd a few slots so that the list search gets exercised
      if (alias_mode && $urandom_range(0, 1) == 1) vtx[7:0] = hot_slot ^ 8'($urandom_range(0, 3));
      case ($urandom_range(0, 30))
        0: vtx = '1;
        1: vtx = '0;
        default: ;
      endcase
      pool.insert(pool.size(), vtx);
    end
    send_vtx(pool[0], 1'b1);
    used = 1;
    len  = distinct * 100 / new_pct + $urandom_range(0, 4);
    for (i = 1; i < len; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        send_vtx($urandom(), ($urandom_range(0, 39) == 0));
      end else if (used < distinct && $urandom_range(1, 100) <= new_pct) begin
        send_vtx(pool[used], 1'b0);
        used++;
      end else begin
        send_vtx(pool[$urandom_range(0, used - 1)], 1'b0);
      end
    end
  endtask

  task automatic run_phase(logic [8:0] cap, int budget, bit big);
    int first;
    set_vertex_cap(cap);
    first = sent_total;
    if (big) run_cluster(262, 92);
    while (sent_total - first < budget) begin
      if ($urandom_range(0, 5) == 0) run_cluster($urandom_range(25, 80), 45);
      else run_cluster($urandom_range(1, 24), 40);
    end
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // before any cluster start, slot collisions, search hits, restart
    send_vtx(32'hFFFF_FFFF, 1'b0);
    send_vtx(32'h0000_0000, 1'b0);
    send_vtx(32'hFFFF_FFFF, 1'b0);
    send_vtx(32'h0000_0100, 1'b0);
    send_vtx(32'h0000_0000, 1'b0);
    send_vtx(32'h0000_0100, 1'b0);
    send_vtx(32'h0000_00FF, 1'b0);
    send_vtx(32'hFFFF_FFFF, 1'b0);
    send_vtx(32'h8000_0000, 1'b1);
    send_vtx(32'h8000_0000, 1'b0);
    send_vtx(32'h0000_0000, 1'b0);
    send_vtx(32'h8000_0000, 1'b1);
    // overflow at the smallest limits
    set_vertex_cap(9'd1);
    send_vtx(32'h1234_5678, 1'b1);
    send_vtx(32'h1234_5679, 1'b0);
    send_vtx(32'h1234_5678, 1'b0);
    send_vtx(32'hA5A5_A5A5, 1'b0);
    set_vertex_cap(9'd0);
    send_vtx(32'h0000_0005, 1'b1);
    send_vtx(32'h0000_0005, 1'b0);
    send_vtx(32'hFFFF_FFFF, 1'b1);
    set_vertex_cap(9'd2);
    send_vtx(32'hDEAD_BEEF, 1'b1);
    send_vtx(32'h0000_0042, 1'b0);
    send_vtx(32'h0000_0042, 1'b0);
    send_vtx(32'h7FFF_FFFF, 1'b0);
    send_vtx(32'hDEAD_BEEF, 1'b0);

    run_phase(9'd256,  70, 1'b0);
    run_phase(9'd2,    60, 1'b0);
    run_phase(9'd64,   80, 1'b0);
    run_phase(9'd511, 300, 1'b1);
    run_phase(9'd17,   70, 1'b0);
    run_phase(9'd300,  50, 1'b0);
    run_phase(9'd1,    40, 1'b0);
    run_phase(9'd255,  80, 1'b0);
    run_phase(9'd0,    20, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("%0d requests in %0d clusters: %0d new vertices, %0d overflows",
             sb.n_requests, sb.n_clusters, sb.n_new, sb.n_ovf);
    $display("%0d direct-slot hits, %0d list-search hits, limits 0 to 511",
             sb.n_slot_hits, sb.n_list_hits);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/cvir_pkg.sv
hdl/cvir_ctrl.sv
hdl/cvir_dpath.sv
hdl/cluster_vertex_index_remap.sv
tb/tb.sv
